@@ rtl/core/qao_pkg.sv @@
package qao_pkg;

    // Width of every packed corner field on the input channel
    localparam int unsigned FIELD_W = 32;

    // Number of separating axes tried, one lane each
    localparam int unsigned NUM_AXES = 4;

    // Number of corners in one quad
    localparam int unsigned NUM_CORNERS = 4;

    // Pipeline control passed to each lane
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

@@ rtl/core/qao_if.sv @@
interface qao_in_if;
    import qao_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_corner_a;
    logic [FIELD_W-1:0] first_corner_b;
    logic [FIELD_W-1:0] first_corner_c;
    logic [FIELD_W-1:0] first_corner_d;
    logic [FIELD_W-1:0] second_corner_a;
    logic [FIELD_W-1:0] second_corner_b;
    logic [FIELD_W-1:0] second_corner_c;
    logic [FIELD_W-1:0] second_corner_d;

    modport source (
        output valid,
        input  ready,
        output first_corner_a, first_corner_b, first_corner_c, first_corner_d,
        output second_corner_a, second_corner_b, second_corner_c, second_corner_d
    );

    modport sink (
        input  valid,
        output ready,
        input  first_corner_a, first_corner_b, first_corner_c, first_corner_d,
        input  second_corner_a, second_corner_b, second_corner_c, second_corner_d
    );
endinterface

interface qao_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid,
        input  ready,
        output overlap
    );

    modport sink (
        input  valid,
        output ready,
        input  overlap
    );
endinterface

@@ rtl/core/qao_lane.sv @@
module qao_lane #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qao_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_e1x,
    input  logic signed [COORD_BITS-1:0]  i_e1y,
    input  logic signed [COORD_BITS-1:0]  i_e2x,
    input  logic signed [COORD_BITS-1:0]  i_e2y,
    input  logic signed [COORD_BITS-1:0]  i_px [qao_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0]  i_py [qao_pkg::NUM_CORNERS],
    output logic                          o_vld,
    output logic                          o_overlap
);
    import qao_pkg::*;

    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * COORD_BITS + 2;
    localparam int unsigned SW = PW + 1;

    // Stage 1: edge direction and corner offsets
    logic                   r_vld1;
    logic signed [DW-1:0]   r_dx, r_dy;
    logic signed [DW-1:0]   r_u1x [NUM_CORNERS];
    logic signed [DW-1:0]   r_u1y [NUM_CORNERS];
    logic signed [DW-1:0]   r_u2x [NUM_CORNERS];
    logic signed [DW-1:0]   r_u2y [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] r_gt1, r_lt1;
    logic                   r_deg1;

    // Stage 2: products
    logic                   r_vld2;
    logic signed [PW-1:0]   r_p1x [NUM_CORNERS];
    logic signed [PW-1:0]   r_p1y [NUM_CORNERS];
    logic signed [PW-1:0]   r_p2x [NUM_CORNERS];
    logic signed [PW-1:0]   r_p2y [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] r_gt2, r_lt2;
    logic                   r_deg2;

    // Stage 3: axis verdict
    logic                   r_vld3;
    logic                   r_ov3;

    logic signed [DW-1:0]   n_dx, n_dy;
    logic [SW-1:0]          n_s1 [NUM_CORNERS];
    logic [SW-1:0]          n_s2 [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] n_beyond1, n_beyond2;
    logic                   n_past1, n_past2;

    assign n_dx = {i_e1x[COORD_BITS-1], i_e1x} - {i_e2x[COORD_BITS-1], i_e2x};
    assign n_dy = {i_e1y[COORD_BITS-1], i_e1y} - {i_e2y[COORD_BITS-1], i_e2y};

    // Valid bits advance with the shared enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld1 <= i_ctl.vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Capture offsets and degenerate-edge compares
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_deg1 <= (n_dx == '0) && (n_dy == '0);
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_u1x[i] <= {i_px[i][COORD_BITS-1], i_px[i]} - {i_e1x[COORD_BITS-1], i_e1x};
                r_u1y[i] <= {i_py[i][COORD_BITS-1], i_py[i]} - {i_e1y[COORD_BITS-1], i_e1y};
                r_u2x[i] <= {i_px[i][COORD_BITS-1], i_px[i]} - {i_e2x[COORD_BITS-1], i_e2x};
                r_u2y[i] <= {i_py[i][COORD_BITS-1], i_py[i]} - {i_e2y[COORD_BITS-1], i_e2y};
                r_gt1[i] <= i_py[i] > i_e1y;
                r_lt1[i] <= i_py[i] < i_e1y;
            end
        end
    end

    // Multiply offsets by the edge direction
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_gt2  <= r_gt1;
            r_lt2  <= r_lt1;
            r_deg2 <= r_deg1;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_p1x[i] <= r_u1x[i] * r_dx;
                r_p1y[i] <= r_u1y[i] * r_dy;
                r_p2x[i] <= r_u2x[i] * r_dx;
                r_p2y[i] <= r_u2y[i] * r_dy;
            end
        end
    end

    // Sum dot products and test each corner against both edge ends
    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            n_s1[i] = {r_p1x[i][PW-1], r_p1x[i]} + {r_p1y[i][PW-1], r_p1y[i]};
            n_s2[i] = {r_p2x[i][PW-1], r_p2x[i]} + {r_p2y[i][PW-1], r_p2y[i]};
            n_beyond1[i] = !n_s1[i][SW-1] && (n_s1[i] != '0);
            n_beyond2[i] = n_s2[i][SW-1];
        end
        n_past1 = r_deg2 ? (&r_gt2) : (&n_beyond1);
        n_past2 = r_deg2 ? (&r_lt2) : (&n_beyond2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ov3 <= !(n_past1 || n_past2);
        end
    end

    assign o_vld     = r_vld3;
    assign o_overlap = r_ov3;

endmodule

@@ rtl/core/quad_overlap_axis_test.sv @@
// Overlap test of two quads by separating axes.
// i_item (sink) takes the four corners of each quad, one item per cycle;
// each corner packs x above y, both signed with COORD_BITS bits.
// o_result (source) returns one overlap bit per item, in order:
// 1 when no separating axis exists, 0 when the quads are apart.
// Four lanes test the axes ab and bc of each quad in parallel; a merge
// register ANDs their verdicts.
// The accepting edge loads the first of four register stages (offsets,
// products, dot-product signs, merge); o_result.valid rises once the item
// reaches the merge register. Throughput: one item per cycle, set by the fully pipelined lanes.
// When the receiver stalls the whole pipeline holds and i_item.ready drops;
// while the output register is empty or being taken, items keep flowing.
// Reset (synchronous, active low) clears all valid bits; no item is pending
// afterwards.
module quad_overlap_axis_test #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qao_in_if.sink   i_item,
    qao_out_if.source o_result
);
    import qao_pkg::*;

    logic [FIELD_W-1:0]          w_field [2*NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_x [2*NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_y [2*NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_q1x [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_q1y [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_q2x [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] w_q2y [NUM_CORNERS];
    logic [NUM_AXES-1:0]          w_vld, w_ov;
    t_pipe_ctl                    w_ctl;
    logic                         r_out_vld, r_overlap;

    assign w_field[0] = i_item.first_corner_a;
    assign w_field[1] = i_item.first_corner_b;
    assign w_field[2] = i_item.first_corner_c;
    assign w_field[3] = i_item.first_corner_d;
    assign w_field[4] = i_item.second_corner_a;
    assign w_field[5] = i_item.second_corner_b;
    assign w_field[6] = i_item.second_corner_c;
    assign w_field[7] = i_item.second_corner_d;

    // Unpack corners; x bits beyond the field read as zero
    for (genvar g = 0; g < 2*NUM_CORNERS; g++) begin : g_unpack
        logic [2*FIELD_W-1:0] w_wide;
        assign w_wide = {{FIELD_W{1'b0}}, w_field[g]};
        assign w_x[g] = w_wide[2*COORD_BITS-1:COORD_BITS];
        assign w_y[g] = w_field[g][COORD_BITS-1:0];
    end

    for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_split
        assign w_q1x[g] = w_x[g];
        assign w_q1y[g] = w_y[g];
        assign w_q2x[g] = w_x[NUM_CORNERS+g];
        assign w_q2y[g] = w_y[NUM_CORNERS+g];
    end

    // Advance the pipeline unless a finished item is blocked
    assign w_ctl.en  = !r_out_vld || o_result.ready;
    assign w_ctl.vld = i_item.valid;
    assign i_item.ready = w_ctl.en;

    // Axis ab of the first quad
    qao_lane #(.COORD_BITS(COORD_BITS)) u_lane_1ab (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_e1x(w_q1x[0]), .i_e1y(w_q1y[0]), .i_e2x(w_q1x[1]), .i_e2y(w_q1y[1]),
        .i_px(w_q2x), .i_py(w_q2y), .o_vld(w_vld[0]), .o_overlap(w_ov[0])
    );

    // Axis bc of the first quad
    qao_lane #(.COORD_BITS(COORD_BITS)) u_lane_1bc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_e1x(w_q1x[1]), .i_e1y(w_q1y[1]), .i_e2x(w_q1x[2]), .i_e2y(w_q1y[2]),
        .i_px(w_q2x), .i_py(w_q2y), .o_vld(w_vld[1]), .o_overlap(w_ov[1])
    );

    // Axis ab of the second quad
    qao_lane #(.COORD_BITS(COORD_BITS)) u_lane_2ab (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_e1x(w_q2x[0]), .i_e1y(w_q2y[0]), .i_e2x(w_q2x[1]), .i_e2y(w_q2y[1]),
        .i_px(w_q1x), .i_py(w_q1y), .o_vld(w_vld[2]), .o_overlap(w_ov[2])
    );

    // Axis bc of the second quad
    qao_lane #(.COORD_BITS(COORD_BITS)) u_lane_2bc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_e1x(w_q2x[1]), .i_e1y(w_q2y[1]), .i_e2x(w_q2x[2]), .i_e2y(w_q2y[2]),
        .i_px(w_q1x), .i_py(w_q1y), .o_vld(w_vld[3]), .o_overlap(w_ov[3])
    );

    // Merge lane verdicts into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctl.en) begin
            r_out_vld <= &w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en) begin
            r_overlap <= &w_ov;
        end
    end

    assign o_result.valid   = r_out_vld;
    assign o_result.overlap = r_overlap;

endmodule
